// ===== rtl/scv_pkg.sv =====
package scv_pkg;

    localparam int unsigned SIGNATURE_BYTES_DEFAULT = 256;
    localparam int unsigned QUEUE_DEPTH             = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_THUMBNAIL  = 3'd1,
        KIND_FRAME_DATA = 3'd2,
        KIND_FRAME_META = 3'd3,
        KIND_SOUND      = 3'd4,
        KIND_UNKNOWN    = 3'd5,
        KIND_PENDING_M  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        END_MORE    = 2'd0,
        END_SIG     = 2'd1,
        END_OVERRUN = 2'd2
    } end_status_t;

    // one classified byte, handed from the front end to the CRC back end
    typedef struct packed {
        logic [7:0]  data;
        logic        open_sec;
        logic        stored_en;
        logic [1:0]  stored_lane;
        logic        track_en;
        logic        crc_en;
        logic        emit;
        logic        trunc;
        logic        checkable;
        logic        sound;
        logic        short_sec;
        kind_t       kind;
        end_status_t status;
        logic        last;
        logic [31:0] base;
    } scv_op_t;

    typedef logic [31:0] crc_table_t [256];

    function automatic crc_table_t gen_crc_table();
        crc_table_t tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = gen_crc_table();

endpackage

// ===== rtl/scv_front.sv =====
module scv_front #(
    parameter int unsigned SIGNATURE_BYTES = scv_pkg::SIGNATURE_BYTES_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_first_byte,
    input  logic [31:0]     file_length,
    input  logic            q_full,
    output logic            q_push,
    output scv_pkg::scv_op_t q_op
);
    import scv_pkg::*;

    localparam logic [31:0] OFS_LEN_FIRST   = 32'd4;
    localparam logic [31:0] OFS_LEN_LAST    = 32'd7;
    localparam logic [31:0] OFS_PLAIN_CRC   = 32'd8;
    localparam logic [31:0] OFS_TRACKS      = 32'd12;
    localparam logic [31:0] OFS_SOUND_CRC   = 32'd32;
    localparam logic [31:0] OFS_CRC_BYTES   = 32'd4;

    logic [31:0] pos_reg, pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] len_reg, len_next;
    kind_t       kind_reg, kind_next;
    logic        done_reg, done_next;

    logic [31:0] pos_cur, r, base_cur, len_cur, crc_ofs;
    kind_t       kind_cur;
    logic        done_cur, accept, at_end, file_last, sound;
    logic [33:0] tail_end;
    end_status_t status;

    always_comb begin
        pos_cur  = s_first_byte ? '0 : pos_reg;
        r        = s_first_byte ? '0 : offset_reg;
        base_cur = s_first_byte ? '0 : base_reg;
        len_cur  = s_first_byte ? '0 : len_reg;
        kind_cur = s_first_byte ? KIND_HEADER : kind_reg;
        done_cur = s_first_byte ? 1'b0 : done_reg;

        s_ready = !q_full;
        accept  = s_valid && !q_full;
        q_push  = accept && !done_cur;

        // section type from magic bytes 1 and 2
        kind_next = kind_cur;
        if (r == 32'd0) begin
            kind_next = KIND_UNKNOWN;
        end else if (r == 32'd1) begin
            unique case (s_data_byte)
                8'h46:   kind_next = KIND_HEADER;
                8'h54:   kind_next = KIND_THUMBNAIL;
                8'h4D:   kind_next = KIND_PENDING_M;
                8'h53:   kind_next = KIND_SOUND;
                default: kind_next = KIND_UNKNOWN;
            endcase
        end else if (r == 32'd2 && kind_cur == KIND_PENDING_M) begin
            unique case (s_data_byte)
                8'h43:   kind_next = KIND_FRAME_DATA;
                8'h49:   kind_next = KIND_FRAME_META;
                default: kind_next = KIND_UNKNOWN;
            endcase
        end

        len_next = (r == 32'd0) ? '0 : len_cur;
        if (r >= OFS_LEN_FIRST && r <= OFS_LEN_LAST) begin
            len_next = len_next | ({24'd0, s_data_byte} << {r[1:0], 3'b000});
        end

        sound   = (kind_next == KIND_SOUND);
        crc_ofs = sound ? OFS_SOUND_CRC : OFS_PLAIN_CRC;

        at_end    = (r >= OFS_LEN_LAST) && ({1'b0, r} == ({1'b0, len_next} + 33'd7));
        file_last = (({1'b0, pos_cur} + 33'd1) >= {1'b0, file_length});
        tail_end  = {2'b00, pos_cur} + 34'd1 + 34'(SIGNATURE_BYTES);
        if (tail_end < {2'b00, file_length}) begin
            status = END_MORE;
        end else if (tail_end == {2'b00, file_length}) begin
            status = END_SIG;
        end else begin
            status = END_OVERRUN;
        end

        q_op.data        = s_data_byte;
        q_op.open_sec    = (r == 32'd0);
        q_op.stored_en   = (r >= crc_ofs) && (r < crc_ofs + OFS_CRC_BYTES);
        q_op.stored_lane = r[1:0];
        q_op.track_en    = sound && (r >= OFS_TRACKS) && (r < OFS_SOUND_CRC);
        q_op.crc_en      = (r >= crc_ofs + OFS_CRC_BYTES);
        q_op.emit        = at_end || file_last;
        q_op.trunc       = !at_end;
        q_op.checkable   = (kind_next == KIND_HEADER) || (kind_next == KIND_THUMBNAIL) ||
                           (kind_next == KIND_FRAME_DATA) || sound;
        q_op.sound       = sound;
        q_op.short_sec   = (r < crc_ofs + OFS_CRC_BYTES - 32'd1);
        q_op.kind        = (kind_next == KIND_PENDING_M) ? KIND_UNKNOWN : kind_next;
        q_op.status      = at_end ? status : END_OVERRUN;
        q_op.last        = at_end ? (status != END_MORE) : 1'b1;
        q_op.base        = base_cur;

        pos_next    = pos_cur + 32'd1;
        offset_next = r + 32'd1;
        base_next   = base_cur;
        done_next   = done_cur;
        if (at_end && status == END_MORE) begin
            offset_next = '0;
            base_next   = pos_cur + 32'd1;
        end else if (q_op.emit) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            offset_reg <= '0;
            base_reg   <= '0;
            len_reg    <= '0;
            kind_reg   <= KIND_HEADER;
            done_reg   <= 1'b0;
        end else if (accept) begin
            if (done_cur) begin
                // walk over: only a restart is recorded
                pos_reg    <= pos_cur;
                offset_reg <= r;
                base_reg   <= base_cur;
                len_reg    <= len_cur;
                kind_reg   <= kind_cur;
                done_reg   <= done_cur;
            end else begin
                pos_reg    <= pos_next;
                offset_reg <= offset_next;
                base_reg   <= base_next;
                len_reg    <= len_next;
                kind_reg   <= kind_next;
                done_reg   <= done_next;
            end
        end
    end

endmodule

// ===== rtl/scv_queue.sv =====
module scv_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  scv_pkg::scv_op_t push_op,
    output logic             full,
    input  logic             pop,
    output scv_pkg::scv_op_t pop_op,
    output logic             empty
);
    import scv_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    scv_op_t            slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slots[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/scv_back.sv =====
module scv_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  scv_pkg::scv_op_t head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_section_kind,
    output logic             m_checked,
    output logic             m_crc_ok,
    output logic [31:0]      m_section_start,
    output logic [1:0]       m_end_status,
    output logic             m_last
);
    import scv_pkg::*;

    logic [31:0] stored_reg, stored_next;
    logic [31:0] crc_reg, crc_next;
    logic        tracks_reg, tracks_next;
    logic [31:0] stored_base, crc_base;
    logic        tracks_base, chk, ok;

    logic        res_valid_reg;
    logic [2:0]  res_kind_reg;
    logic        res_checked_reg, res_ok_reg, res_last_reg;
    logic [31:0] res_start_reg;
    logic [1:0]  res_status_reg;

    always_comb begin
        stored_base = head.open_sec ? '0 : stored_reg;
        crc_base    = head.open_sec ? CRC_INIT : crc_reg;
        tracks_base = head.open_sec ? 1'b0 : tracks_reg;

        stored_next = stored_base;
        if (head.stored_en) begin
            stored_next = stored_base | ({24'd0, head.data} << {head.stored_lane, 3'b000});
        end
        crc_next = crc_base;
        if (head.crc_en) begin
            crc_next = CRC_TABLE[crc_base[7:0] ^ head.data] ^ (crc_base >> 8);
        end
        tracks_next = tracks_base || (head.track_en && (head.data != 8'd0));

        priority if (head.trunc) begin
            chk = 1'b0;
            ok  = 1'b0;
        end else if (!head.checkable) begin
            chk = 1'b0;
            ok  = 1'b1;
        end else if (head.short_sec) begin
            chk = 1'b0;
            ok  = 1'b0;
        end else if (head.sound && !tracks_next) begin
            chk = 1'b0;
            ok  = 1'b1;
        end else begin
            chk = 1'b1;
            ok  = (stored_next == ~crc_next);
        end

        // a result needs the output slot free or draining this cycle
        q_pop = !q_empty && (!head.emit || !res_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            stored_reg <= stored_next;
            crc_reg    <= crc_next;
            tracks_reg <= tracks_next;
        end
        if (q_pop && head.emit) begin
            res_kind_reg    <= head.kind;
            res_checked_reg <= chk;
            res_ok_reg      <= ok;
            res_start_reg   <= head.base;
            res_status_reg  <= head.status;
            res_last_reg    <= head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (q_pop && head.emit) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = res_valid_reg;
    assign m_section_kind  = res_kind_reg;
    assign m_checked       = res_checked_reg;
    assign m_crc_ok        = res_ok_reg;
    assign m_section_start = res_start_reg;
    assign m_end_status    = res_status_reg;
    assign m_last          = res_last_reg;

endmodule

// ===== rtl/section_crc_verifier_unit.sv =====
// channel   | direction | payload
// ----------+-----------+---------------------------------------------------------
// s_        | in        | data_byte[7:0], first_byte
// m_        | out       | section_kind[2:0], checked, crc_ok, section_start[31:0],
//           |           | end_status[1:0], last
// apb       | in        | file_length at address 0
//
// One byte per cycle while the queue has room; a result is registered once the section's last byte leaves the queue.
// Front end tracks offsets and magic, a 4-deep queue feeds the table-driven CRC back end.
// Synchronous active-low reset clears walk state, queue and output valid.
// A stalled m_ fills the queue; s_ready drops only when the queue is full.
module section_crc_verifier_unit #(
    parameter int unsigned SIGNATURE_BYTES = scv_pkg::SIGNATURE_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_section_kind,
    output logic        m_checked,
    output logic        m_crc_ok,
    output logic [31:0] m_section_start,
    output logic [1:0]  m_end_status,
    output logic        m_last
);
    import scv_pkg::*;

    logic [31:0] file_length_reg;
    logic        q_push, q_full, q_pop, q_empty;
    scv_op_t     push_op, head_op;

    assign pready = 1'b1;
    // single register; every word address maps onto it
    assign prdata = (paddr == 2'd0) ? file_length_reg : file_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            file_length_reg <= pwdata;
        end
    end

    scv_front #(
        .SIGNATURE_BYTES(SIGNATURE_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_first_byte(s_first_byte),
        .file_length (file_length_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (push_op)
    );

    scv_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (head_op),
        .empty   (q_empty)
    );

    scv_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head_op),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_section_kind (m_section_kind),
        .m_checked      (m_checked),
        .m_crc_ok       (m_crc_ok),
        .m_section_start(m_section_start),
        .m_end_status   (m_end_status),
        .m_last         (m_last)
    );

`ifndef SYNTHESIS
    a_checked_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checked |-> (m_section_kind == KIND_HEADER ||
            m_section_kind == KIND_THUMBNAIL || m_section_kind == KIND_FRAME_DATA ||
            m_section_kind == KIND_SOUND))
        else $error("CRC compared on a kind that carries no CRC");

    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_end_status != END_MORE)))
        else $error("last flag disagrees with end status");

    a_fail_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_checked && !m_crc_ok |-> (m_end_status == END_OVERRUN ||
            m_section_kind == KIND_HEADER || m_section_kind == KIND_THUMBNAIL ||
            m_section_kind == KIND_FRAME_DATA || m_section_kind == KIND_SOUND))
        else $error("unchecked failure without truncation or short section");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("transaction pushed into full queue");
`endif

endmodule
